>>> sv/srrf_pkg.sv
// Shared types, constants and helpers for the short run removal filter.
package srrf_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned COL_W       = 13;
  localparam int unsigned RUN_W       = 7;
  localparam int unsigned MAX_COLUMNS = 4096;
  localparam int unsigned MAX_RUN     = 64;
  localparam int unsigned ADDR_W      = $clog2(MAX_RUN);
  localparam int unsigned CMD_DEPTH   = 4;
  localparam int unsigned CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROI_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN   = 2'd2;

  localparam logic [COL_W-1:0] ROI_START_RST = 13'd410;
  localparam logic [COL_W-1:0] ROI_END_RST   = 13'd460;
  localparam logic [RUN_W-1:0] MIN_RUN_RST   = 7'd10;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             row_last;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end_out;
    logic             burst_last;
  } out_item_t;

  typedef struct packed {
    logic [COL_W-1:0] roi_start;
    logic [COL_W-1:0] roi_end;
    logic [RUN_W-1:0] min_run;
  } cfg_t;

  // What precedes the current pixel in a burst.
  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_ZEROS,
    PRE_REPLAY
  } pre_mode_e;

  // One command per accepted item, executed in order by the back end.
  typedef struct packed {
    logic              store_en;
    logic [ADDR_W-1:0] store_addr;
    logic [PIX_W-1:0]  store_data;
    pre_mode_e         pre_mode;
    logic [RUN_W-1:0]  pre_cnt;
    logic              pix_en;
    logic [PIX_W-1:0]  pix;
    logic              row_end;
  } cmd_t;

endpackage

>>> sv/srrf_front.sv
// Front end: tracks column and run state and turns each item into one command.
module srrf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srrf_pkg::cfg_t   cfg_i,
  input  logic             item_valid_i,
  input  srrf_pkg::in_item_t item_i,
  output srrf_pkg::cmd_t   cmd_o
);

  logic [srrf_pkg::COL_W-1:0] col_q, col_d;
  logic                       open_q, open_d;
  logic                       conf_q, conf_d;
  logic [srrf_pkg::RUN_W-1:0] held_q, held_d;

  logic [srrf_pkg::RUN_W-1:0] thr;
  logic                       in_win;
  logic [srrf_pkg::RUN_W-1:0] held_inc;

  always_comb begin
    // Clamp threshold to 1..MAX_RUN.
    if (cfg_i.min_run == '0) begin
      thr = srrf_pkg::RUN_W'(1);
    end else if (cfg_i.min_run > srrf_pkg::RUN_W'(srrf_pkg::MAX_RUN)) begin
      thr = srrf_pkg::RUN_W'(srrf_pkg::MAX_RUN);
    end else begin
      thr = cfg_i.min_run;
    end
    in_win = (col_q >= cfg_i.roi_start) && (col_q < cfg_i.roi_end) &&
             (col_q < srrf_pkg::COL_W'(srrf_pkg::MAX_COLUMNS));
  end

  always_comb begin
    col_d    = col_q;
    open_d   = open_q;
    conf_d   = conf_q;
    held_d   = held_q;
    held_inc = '0;

    cmd_o            = '0;
    cmd_o.pre_mode   = srrf_pkg::PRE_NONE;
    cmd_o.pix        = item_i.pixel_in;
    cmd_o.store_data = item_i.pixel_in;
    cmd_o.row_end    = item_i.row_last;

    if (in_win && (item_i.pixel_in != '0)) begin
      if (!open_q) begin
        open_d = 1'b1;
        conf_d = 1'b0;
        held_d = '0;
      end
      if (conf_d) begin
        cmd_o.pix_en = 1'b1;
      end else begin
        // Hold the pixel until the run is decided.
        held_inc         = held_d + srrf_pkg::RUN_W'(1);
        cmd_o.store_en   = 1'b1;
        cmd_o.store_addr = held_d[srrf_pkg::ADDR_W-1:0];
        held_d           = held_inc;
        if (held_inc >= thr) begin
          cmd_o.pre_mode = srrf_pkg::PRE_REPLAY;
          cmd_o.pre_cnt  = held_inc;
          held_d         = '0;
          conf_d         = 1'b1;
        end
      end
      if (item_i.row_last) begin
        if (!conf_d) begin
          cmd_o.pre_mode = srrf_pkg::PRE_ZEROS;
          cmd_o.pre_cnt  = held_d;
        end
        held_d = '0;
        open_d = 1'b0;
        conf_d = 1'b0;
      end
    end else begin
      if (open_q && !conf_q) begin
        cmd_o.pre_mode = srrf_pkg::PRE_ZEROS;
        cmd_o.pre_cnt  = held_q;
      end
      held_d       = '0;
      open_d       = 1'b0;
      conf_d       = 1'b0;
      cmd_o.pix_en = 1'b1;
    end

    if (item_i.row_last) begin
      col_d = '0;
    end else if (col_q < srrf_pkg::COL_W'(srrf_pkg::MAX_COLUMNS)) begin
      col_d = col_q + srrf_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      open_q <= 1'b0;
      conf_q <= 1'b0;
      held_q <= '0;
    end else if (item_valid_i) begin
      col_q  <= col_d;
      open_q <= open_d;
      conf_q <= conf_d;
      held_q <= held_d;
    end
  end

endmodule

>>> sv/srrf_cmd_fifo.sv
// Short command queue between front and back ends.
module srrf_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srrf_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output srrf_pkg::cmd_t head_o
);

  srrf_pkg::cmd_t                 slot_q [srrf_pkg::CMD_DEPTH];
  logic [srrf_pkg::CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [srrf_pkg::CMD_PTR_W:0]   cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == (srrf_pkg::CMD_PTR_W+1)'(srrf_pkg::CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + srrf_pkg::CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + srrf_pkg::CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (srrf_pkg::CMD_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (srrf_pkg::CMD_PTR_W+1)'(1);
      end
    end
  end

endmodule

>>> sv/srrf_back.sv
// Back end: executes commands, owns the hold buffer and the output register.
module srrf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  srrf_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic                pop_i,
  output logic                out_valid_o,
  output srrf_pkg::out_item_t out_item_o
);

  logic [srrf_pkg::PIX_W-1:0] hold_mem_q [srrf_pkg::MAX_RUN];
  logic [srrf_pkg::PIX_W-1:0] rd_data_q;

  srrf_pkg::cmd_t             cur_q;
  logic                       busy_q, busy_d;
  logic                       wait_q, wait_d;
  logic [srrf_pkg::RUN_W-1:0] idx_q, idx_d;
  logic [srrf_pkg::RUN_W-1:0] total;
  logic                       has_work;
  logic                       last_item;
  logic                       out_ready;
  logic                       emit;
  logic                       out_valid_q, out_valid_d;
  srrf_pkg::out_item_t        out_q, out_d;

  assign cmd_pop_o = cmd_valid_i && !busy_q;
  assign has_work  = (cmd_i.pre_cnt != '0) || cmd_i.pix_en;
  assign total     = cur_q.pre_cnt + srrf_pkg::RUN_W'(cur_q.pix_en);
  assign last_item = (idx_q == total - srrf_pkg::RUN_W'(1));
  assign out_ready = !out_valid_q || pop_i;
  // After a replay load, hold off emission so the buffer read sees the stored pixel.
  assign emit      = busy_q && !wait_q && out_ready;

  always_comb begin
    busy_d      = busy_q;
    wait_d      = 1'b0;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;

    if (cmd_pop_o) begin
      busy_d = has_work;
      wait_d = (cmd_i.pre_mode == srrf_pkg::PRE_REPLAY);
      idx_d  = '0;
    end else if (emit) begin
      idx_d       = idx_q + srrf_pkg::RUN_W'(1);
      busy_d      = !last_item;
      out_valid_d = 1'b1;
      if (idx_q < cur_q.pre_cnt) begin
        case (cur_q.pre_mode)
          srrf_pkg::PRE_REPLAY: out_d.pixel_out = rd_data_q;
          default:              out_d.pixel_out = '0;
        endcase
      end else begin
        out_d.pixel_out = cur_q.pix;
      end
      out_d.burst_last  = last_item;
      out_d.row_end_out = last_item && cur_q.row_end;
    end
  end

  // Hold buffer: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.store_en) begin
      hold_mem_q[cmd_i.store_addr] <= cmd_i.store_data;
    end
    rd_data_q <= hold_mem_q[idx_d[srrf_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      wait_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      wait_q      <= wait_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_wait_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q |-> busy_q)
    else $error("read wait cycle outside a burst");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !wait_q) |-> (idx_q < total))
    else $error("burst index past burst length");

  a_replay_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && (cmd_i.pre_mode == srrf_pkg::PRE_REPLAY)) |->
      (cmd_i.pre_cnt != '0) && cmd_i.store_en)
    else $error("replay command without stored pixels");

  a_emit_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("emitted item not shown");
`endif

endmodule

>>> sv/short_run_removal_filter.sv
// Top level of the short run removal filter: config registers and part wiring.
//
// Use: mask pixels enter row-major on the input queue side (push/full,
// in_item_i); row_last marks the last pixel of each row. Inside the column
// window [roi_start, roi_end) runs of nonzero pixels shorter than min_run are
// replaced by zeros; everything else passes unchanged, in stream order.
// Filtered items leave on the result queue side (empty/pop, out_item_o);
// burst_last flags the last result caused by one input pixel.
// A passing pixel goes through the command queue, the back end's command
// register and the output register. A pixel that joins an undecided run
// gives no result until the run is decided; then, after a wait for the
// buffer read, the held run is replayed at one item per cycle while the
// receiver keeps popping. The back end loads a command, then emits its
// results, and takes no new command until its last result is emitted.
// A four-entry command queue lets the front keep taking pixels while the
// back end drains a burst; full rises when that queue fills.
// Reset clears the column counter, run state and queues; registers take
// their defaults (410, 460, 10). If the receiver stops popping, the output
// register holds its item, the back end stalls, then the queue and input.
module short_run_removal_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [srrf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [srrf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input queue side
  input  logic                             push,
  output logic                             full,
  input  srrf_pkg::in_item_t               in_item_i,
  // result queue side
  output logic                             empty,
  input  logic                             pop,
  output srrf_pkg::out_item_t              out_item_o
);

  srrf_pkg::cfg_t cfg_q;
  srrf_pkg::cmd_t front_cmd;
  srrf_pkg::cmd_t head_cmd;
  logic           item_acc;
  logic           cmd_full;
  logic           cmd_valid;
  logic           cmd_pop;
  logic           out_valid;

  // Write configuration; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roi_start <= srrf_pkg::ROI_START_RST;
      cfg_q.roi_end   <= srrf_pkg::ROI_END_RST;
      cfg_q.min_run   <= srrf_pkg::MIN_RUN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srrf_pkg::REG_ROI_START: cfg_q.roi_start <= cfg_data_i;
        srrf_pkg::REG_ROI_END:   cfg_q.roi_end   <= cfg_data_i;
        srrf_pkg::REG_MIN_RUN:   cfg_q.min_run   <= cfg_data_i[srrf_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept a pixel whenever the command queue has room.
  assign full     = cmd_full;
  assign item_acc = push && !cmd_full;

  srrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_acc),
    .item_i       (in_item_i),
    .cmd_o        (front_cmd)
  );

  srrf_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (item_acc),
    .push_data_i (front_cmd),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .valid_o     (cmd_valid),
    .head_o      (head_cmd)
  );

  srrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o)
  );

  assign empty = !out_valid;

endmodule
